[rtl/qft_pkg.sv]
// shared types, constants and codes for the quoted field tokenizer
`timescale 1ns / 1ps
package qft_pkg;

  localparam int SET_SLOTS      = 8;
  localparam int QUOTE_PAIRS    = 4;
  localparam int DEPTH_BITS_DEF = 8;

  localparam int SET_SCAN   = (SET_SLOTS < 8) ? SET_SLOTS : 8;
  localparam int QUOTE_SCAN = (QUOTE_PAIRS < 4) ? QUOTE_PAIRS : 4;
  localparam int SIDX_W     = (SET_SCAN > 1) ? $clog2(SET_SCAN) : 1;
  localparam int QIDX_W     = (QUOTE_SCAN > 1) ? $clog2(QUOTE_SCAN) : 1;

  localparam int TOKEN_LEN_W = 12;
  localparam int CAP_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int MAX_RESULTS = 3;
  localparam int PUSH_W      = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [3:0] BRK_NONE  = -4'sd1;
  localparam logic signed [2:0] QIDX_NONE = -3'sd1;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_TOKEN = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHITE = 3'd0,
    CFG_DELIM = 3'd1,
    CFG_OPEN  = 3'd2,
    CFG_CLOSE = 3'd3,
    CFG_ESC   = 3'd4,
    CFG_CAP   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [63:0]      white;
    logic [63:0]      delim;
    logic [31:0]      open_q;
    logic [31:0]      close_q;
    logic [7:0]       esc;
    logic [CAP_W-1:0] cap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    white:   64'h0920,
    delim:   64'h002C,
    open_q:  32'h2722,
    close_q: 32'h2722,
    esc:     8'h00,
    cap:     13'd256
  };

  typedef struct packed {
    logic              d_hit;
    logic [SIDX_W-1:0] d_idx;
    logic              o_hit;
    logic [QIDX_W-1:0] o_idx;
    logic              o_closes;
    logic              k_hit;
    logic [QIDX_W-1:0] k_idx;
    logic              w_hit;
    logic              e_hit;
  } class_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              token_char;
    logic signed [3:0]       break_index;
    logic signed [2:0]       quote_index;
    logic [TOKEN_LEN_W-1:0]  token_length;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [PUSH_W-1:0]                count;
    result_t [MAX_RESULTS-1:0]        item;
  } push_t;

endpackage

[rtl/qft_if.sv]
// input and result channel interfaces of the tokenizer
`timescale 1ns / 1ps
interface qft_in_if;
  import qft_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_value;
  logic       line_end;

  modport source (output valid, output char_value, output line_end, input ready);
  modport sink (input valid, input char_value, input line_end, output ready);
endinterface

interface qft_out_if;
  import qft_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [7:0]             token_char;
  logic signed [3:0]      break_index;
  logic signed [2:0]      quote_index;
  logic [TOKEN_LEN_W-1:0] token_length;
  logic                   last;

  modport source (output valid, output kind, output token_char, output break_index,
                  output quote_index, output token_length, output last, input ready);
  modport sink (input valid, input kind, input token_char, input break_index,
                input quote_index, input token_length, input last, output ready);
endinterface

[rtl/qft_classify.sv]
// parallel character set matching for one input character
`timescale 1ns / 1ps
module qft_classify (
  input  logic [7:0]      char_value,
  input  qft_pkg::cfg_t   cfg,
  output qft_pkg::class_t cl
);
  import qft_pkg::*;

  // returns {hit, slot}; a zero byte ends the list
  function automatic logic [3:0] find_slot(input logic [63:0] list, input int slots,
                                           input logic [7:0] ch);
    logic       alive;
    logic [3:0] r;
    alive = 1'b1;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < slots && alive && !r[3]) begin
        if (list[8*i +: 8] == 8'd0) begin
          alive = 1'b0;
        end else if (list[8*i +: 8] == ch) begin
          r = {1'b1, 3'(i)};
        end
      end
    end
    return r;
  endfunction

  logic [3:0] d_f, o_f, k_f, w_f;

  assign d_f = find_slot(cfg.delim, SET_SCAN, char_value);
  assign w_f = find_slot(cfg.white, SET_SCAN, char_value);
  assign o_f = find_slot({32'd0, cfg.open_q}, QUOTE_SCAN, char_value);
  assign k_f = find_slot({32'd0, cfg.close_q}, QUOTE_SCAN, char_value);

  always_comb begin
    cl.d_hit    = d_f[3];
    cl.d_idx    = SIDX_W'(d_f[2:0]);
    cl.o_hit    = o_f[3];
    cl.o_idx    = QIDX_W'(o_f[2:0]);
    cl.o_closes = (cfg.close_q[{cl.o_idx, 3'b000} +: 8] == char_value);
    cl.k_hit    = k_f[3];
    cl.k_idx    = QIDX_W'(k_f[2:0]);
    cl.w_hit    = w_f[3];
    cl.e_hit    = (cfg.esc != 8'd0) && (cfg.esc == char_value);
  end

endmodule

[rtl/qft_engine.sv]
// tokenizer state machine and per-transaction result generation
`timescale 1ns / 1ps
module qft_engine #(
  parameter int DEPTH_BITS = qft_pkg::DEPTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      char_value,
  input  logic            line_end,
  input  qft_pkg::cfg_t   cfg,
  input  qft_pkg::class_t cl,
  output qft_pkg::push_t  push
);
  import qft_pkg::*;

  typedef enum logic [1:0] {ST_WHITE, ST_TOKEN, ST_QUOTE, ST_AFTER} st_t;

  typedef struct packed {
    st_t                                   st;
    logic                                  aq_vld;
    logic [QIDX_W-1:0]                     aq_idx;
    logic [QUOTE_SCAN-1:0][DEPTH_BITS-1:0] dep;
    logic [TOKEN_LEN_W-1:0]                cnt;
    logic                                  esc;
    logic                                  started;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{
    st: ST_WHITE, aq_vld: 1'b0, aq_idx: '0, dep: '0, cnt: '0, esc: 1'b0, started: 1'b0
  };

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  function automatic result_t mk_res(input kind_t k, input logic [7:0] ch,
                                     input logic signed [3:0] b, input logic signed [2:0] q,
                                     input logic [TOKEN_LEN_W-1:0] len);
    result_t r;
    r.kind         = k;
    r.token_char   = ch;
    r.break_index  = b;
    r.quote_index  = q;
    r.token_length = len;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic can_store(input logic [TOKEN_LEN_W-1:0] cnt,
                                     input logic [CAP_W-1:0] cap);
    return (({1'b0, cnt} + CAP_W'(1)) < cap) && (cnt != '1);
  endfunction

  function automatic logic signed [2:0] quote_of(input tok_t t);
    return t.aq_vld ? $signed(3'(t.aq_idx)) : QIDX_NONE;
  endfunction

  tok_t  tok_r, tok_nxt;
  logic  disc_r, disc_nxt;
  push_t pw;

  always_comb begin
    tok_t              t;
    logic              again;
    logic              do_store;
    logic              do_finish;
    logic signed [3:0] fin_brk;
    t         = tok_r;
    disc_nxt  = disc_r;
    again     = 1'b0;
    do_store  = 1'b0;
    do_finish = 1'b0;
    fin_brk   = BRK_NONE;
    pw.count  = '0;
    for (int j = 0; j < MAX_RESULTS; j++) begin
      pw.item[j] = mk_res(KIND_CHAR, 8'd0, BRK_NONE, QIDX_NONE, '0);
    end

    if (line_end) begin
      if (!disc_r) begin
        if (t.esc && can_store(t.cnt, cfg.cap)) begin
          t.cnt = t.cnt + TOKEN_LEN_W'(1);
          pw.item[pw.count] = mk_res(KIND_CHAR, cfg.esc, BRK_NONE, QIDX_NONE, '0);
          pw.count = pw.count + PUSH_W'(1);
        end
        if (t.started) begin
          pw.item[pw.count] = mk_res(KIND_TOKEN, 8'd0, BRK_NONE, quote_of(t), t.cnt);
          pw.count = pw.count + PUSH_W'(1);
        end
      end
      pw.item[pw.count] = mk_res(KIND_LINE, 8'd0, BRK_NONE, QIDX_NONE, '0);
      pw.count = pw.count + PUSH_W'(1);
      t = TOK_CLEAR;
      disc_nxt = 1'b0;
    end else if (!disc_r) begin
      if (t.esc) begin
        t.esc = 1'b0;
        if (t.st == ST_AFTER) begin
          pw.item[pw.count] = mk_res(KIND_TOKEN, 8'd0, BRK_NONE, quote_of(t), t.cnt);
          pw.count = pw.count + PUSH_W'(1);
          t = TOK_CLEAR;
          t.st = ST_TOKEN;
          t.started = 1'b1;
        end
        if (can_store(t.cnt, cfg.cap)) begin
          t.cnt = t.cnt + TOKEN_LEN_W'(1);
          pw.item[pw.count] = mk_res(KIND_CHAR, char_value, BRK_NONE, QIDX_NONE, '0);
          pw.count = pw.count + PUSH_W'(1);
        end
      end else begin
        // a cut-short token hands the character to a second pass in white state
        for (int p = 0; p < 2; p++) begin
          if (p == 0 || again) begin
            again     = 1'b0;
            do_store  = 1'b0;
            do_finish = 1'b0;
            fin_brk   = BRK_NONE;
            t.started = 1'b1;
            if (cl.d_hit) begin
              if (t.st == ST_QUOTE) begin
                do_store = 1'b1;
              end else begin
                do_finish = 1'b1;
                fin_brk = $signed(4'(cl.d_idx));
              end
            end else if (cl.o_hit) begin
              unique case (t.st)
                ST_WHITE: begin
                  t.st = ST_QUOTE;
                  t.aq_vld = 1'b1;
                  t.aq_idx = cl.o_idx;
                  if (t.dep[cl.o_idx] != DEPTH_MAX) begin
                    t.dep[cl.o_idx] = t.dep[cl.o_idx] + DEPTH_BITS'(1);
                  end
                end
                ST_QUOTE: begin
                  if (t.aq_vld && t.aq_idx == cl.o_idx) begin
                    if (cl.o_closes && cl.k_hit) begin
                      t.st = ST_AFTER;
                      if (t.dep[cl.o_idx] != '0) begin
                        t.dep[cl.o_idx] = t.dep[cl.o_idx] - DEPTH_BITS'(1);
                      end
                    end else begin
                      if (t.dep[cl.o_idx] != DEPTH_MAX) begin
                        t.dep[cl.o_idx] = t.dep[cl.o_idx] + DEPTH_BITS'(1);
                      end
                      do_store = 1'b1;
                    end
                  end else begin
                    do_store = 1'b1;
                  end
                end
                default: begin
                  do_finish = 1'b1;
                  again = 1'b1;
                end
              endcase
            end else if (cl.k_hit) begin
              if (t.st == ST_QUOTE) begin
                if (t.dep[cl.k_idx] > DEPTH_BITS'(1)) begin
                  do_store = 1'b1;
                  t.dep[cl.k_idx] = t.dep[cl.k_idx] - DEPTH_BITS'(1);
                end else if (t.dep[cl.k_idx] == '0) begin
                  do_store = 1'b1;
                end else begin
                  t.st = ST_AFTER;
                  t.dep[cl.k_idx] = '0;
                end
              end else begin
                pw.item[pw.count] = mk_res(KIND_ERROR, 8'd0, BRK_NONE,
                                           $signed(3'(cl.k_idx)), '0);
                pw.count = pw.count + PUSH_W'(1);
                disc_nxt = 1'b1;
              end
            end else if (cl.w_hit) begin
              if (t.st == ST_TOKEN) begin
                t.st = ST_AFTER;
              end else if (t.st == ST_QUOTE) begin
                do_store = 1'b1;
              end
            end else if (cl.e_hit) begin
              if (t.st == ST_WHITE) begin
                t.st = ST_TOKEN;
              end
              t.esc = 1'b1;
            end else if (t.st == ST_AFTER) begin
              do_finish = 1'b1;
              again = 1'b1;
            end else begin
              if (t.st == ST_WHITE) begin
                t.st = ST_TOKEN;
              end
              do_store = 1'b1;
            end

            if (do_finish) begin
              pw.item[pw.count] = mk_res(KIND_TOKEN, 8'd0, fin_brk, quote_of(t), t.cnt);
              pw.count = pw.count + PUSH_W'(1);
              t = TOK_CLEAR;
            end
            if (do_store && can_store(t.cnt, cfg.cap)) begin
              t.cnt = t.cnt + TOKEN_LEN_W'(1);
              pw.item[pw.count] = mk_res(KIND_CHAR, char_value, BRK_NONE, QIDX_NONE, '0);
              pw.count = pw.count + PUSH_W'(1);
            end
          end
        end
      end
    end

    if (pw.count != '0) begin
      pw.item[pw.count - PUSH_W'(1)].last = 1'b1;
    end
    tok_nxt = t;
  end

  assign push = accept ? pw : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= TOK_CLEAR;
      disc_r <= 1'b0;
    end else if (accept) begin
      tok_r  <= tok_nxt;
      disc_r <= disc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !line_end && disc_r |-> push.count == '0)
    else $error("result produced while discarding rest of line");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && line_end |=> tok_r.st == ST_WHITE && !disc_r && !tok_r.started)
    else $error("line end did not return scanner to white state");

  a_discard_holds: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r && !(accept && line_end) |=> disc_r)
    else $error("discard mode left before line end");
`endif

endmodule

[rtl/qft_result_queue.sv]
// small result queue taking up to three results per transaction
`timescale 1ns / 1ps
module qft_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  qft_pkg::push_t   push,
  output logic             in_ready,
  qft_out_if.source        out_ch
);
  import qft_pkg::*;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = QPTR_W + 1;

  result_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt, tail;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pop;
  result_t           head_item;

  assign tail      = head_r + count_r[QPTR_W-1:0];
  assign head_item = mem_r[head_r];
  assign pop       = out_ch.valid && out_ch.ready;
  assign in_ready  = (count_r <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
  assign head_nxt  = pop ? head_r + QPTR_W'(1) : head_r;
  assign count_nxt = count_r + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
    for (int e = 0; e < QUEUE_DEPTH; e++) begin
      for (int j = 0; j < MAX_RESULTS; j++) begin
        if (PUSH_W'(j) < push.count && QPTR_W'(tail + QPTR_W'(j)) == QPTR_W'(e)) begin
          mem_r[e] <= push.item[j];
        end
      end
    end
  end

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.kind         = head_item.kind;
  assign out_ch.token_char   = head_item.token_char;
  assign out_ch.break_index  = head_item.break_index;
  assign out_ch.quote_index  = head_item.quote_index;
  assign out_ch.token_length = head_item.token_length;
  assign out_ch.last         = head_item.last;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != '0 |-> count_r <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS))
    else $error("results pushed without room in queue");
`endif

endmodule

[rtl/quoted_field_tokenizer.sv]
// top level of the quoted field tokenizer: configuration registers and datapath
// Takes one character or line-end transaction per clock and cuts lines into
// tokens using the configured whitespace, delimiter, quote and escape sets,
// all matched by parallel compares in the cycle the transaction is accepted.
// Each transaction yields zero to three results, written into a four-entry
// result queue; the first, if the queue was empty, is offered on the result
// channel in the next cycle, and the queue delivers one result per cycle while
// the sink is ready. Input is accepted whenever the queue holds at most one
// result, so with one result per transaction and a ready sink the block sustains
// one transaction per cycle; transactions that yield more results are paced by
// the one-per-cycle queue drain. Configuration writes take effect next cycle.
`timescale 1ns / 1ps
module quoted_field_tokenizer #(
  parameter int DEPTH_BITS = qft_pkg::DEPTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  qft_in_if.sink                         in_ch,
  qft_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [qft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qft_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import qft_pkg::*;

  cfg_t   cfg_r;
  class_t cl;
  push_t  push;
  logic   q_ready;
  logic   accept;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHITE: cfg_r.white   <= cfg_wdata;
        CFG_DELIM: cfg_r.delim   <= cfg_wdata;
        CFG_OPEN:  cfg_r.open_q  <= cfg_wdata[31:0];
        CFG_CLOSE: cfg_r.close_q <= cfg_wdata[31:0];
        CFG_ESC:   cfg_r.esc     <= cfg_wdata[7:0];
        CFG_CAP:   cfg_r.cap     <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  qft_classify u_classify (
    .char_value (in_ch.char_value),
    .cfg        (cfg_r),
    .cl         (cl)
  );

  qft_engine #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .char_value (in_ch.char_value),
    .line_end   (in_ch.line_end),
    .cfg        (cfg_r),
    .cl         (cl),
    .push       (push)
  );

  qft_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_ready (q_ready),
    .out_ch   (out_ch)
  );

endmodule
